[sv/tkt_pkg.sv]
package tkt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int KEY_W           = 16;
    localparam int VAL_W           = 32;
    localparam int GRP_W           = 3;
    localparam int GRP_MAX         = 4;
    localparam int STAT_W          = 2;
    localparam int SLOT_OUT_W      = 5;
    localparam int IN_DATA_W       = 152;
    localparam int OUT_DATA_W      = 56;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    // result status codes
    localparam logic [STAT_W-1:0] ST_UPDATED = 2'd0;
    localparam logic [STAT_W-1:0] ST_ALLOC   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_FETCH   = 2'd3;

    // item kinds
    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_FETCH  = 1'b1;

    // one result item handed from the engine to the output stage
    typedef struct packed {
        logic                  full_error;
        logic [VAL_W-1:0]      pair_value;
        logic [KEY_W-1:0]      pair_key;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [STAT_W-1:0]     status;
    } res_t;

    // group size 0 counts as 1, anything above four as four
    function automatic logic [GRP_W-1:0] norm_group(input logic [GRP_W-1:0] g);
        logic [GRP_W-1:0] r;
        begin
            r = g;
            if (g == '0)
                r = GRP_W'(1);
            else if (g > GRP_W'(GRP_MAX))
                r = GRP_W'(GRP_MAX);
            return r;
        end
    endfunction

endpackage

[sv/telemetry_key_table_round_robin_top.sv]
// Telemetry slot table: update beats (tuser 0) look up a 16-bit key among the used slots and
// write one to four values into its group, allocating the next free consecutive slots for a
// new key or reporting a sticky full error; fetch beats (tuser 1) return the next key and
// value in round-robin order. Each beat yields exactly one result beat. The block holds one
// item at a time: a fetch reads at most one slot and then builds its result, while an update
// is paced by the key search that reads one slot per cycle from the key memory followed by
// one value write per cycle. A finished result sits in the output register, so the next item
// is accepted while it waits. Table contents need no clearing pass after reset, since only
// slots below the fill count are ever read.
module telemetry_key_table_round_robin_top #(
    parameter int TABLE_DEPTH = tkt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // fields from bit 0: app_key, group_size, value_0, value_1, value_2, value_3, zero pad
    input  logic [tkt_pkg::IN_DATA_W-1:0]    s_tdata,
    // fields from bit 0: kind
    input  logic                             s_tuser,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // fields from bit 0: status, slot_index, pair_key, pair_value, full_error
    output logic [tkt_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tkt_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tkt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tkt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import tkt_pkg::*;

    localparam logic REG_UNUSED_KEY = 1'b0;

    logic [KEY_W-1:0]      unused_key_reg;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                  res_valid;
    logic                  res_ready;
    res_t                  res;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_UNUSED_KEY) ? APB_DATA_W'(unused_key_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            unused_key_reg <= '0;
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_UNUSED_KEY))
            unused_key_reg <= pwdata[KEY_W-1:0];
    end

    tkt_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .unused_key_code (unused_key_reg),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_kind         (s_tuser),
        .in_key          (s_tdata[KEY_W-1:0]),
        .in_group        (s_tdata[KEY_W +: GRP_W]),
        .in_values       (s_tdata[KEY_W+GRP_W +: 4*VAL_W]),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res)
    );

    // output register
    assign res_ready = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (res_ready)
            m_tvalid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            m_tdata_reg <= OUT_DATA_W'(res);
    end

    // checks
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while one is in work");

    a_handover: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> (m_tvalid && m_tdata == OUT_DATA_W'($past(res))))
        else $error("result beat lost in output register");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == ST_FULL) |-> res.full_error)
        else $error("rejected allocation without full error");

endmodule

[sv/tkt_engine.sv]
module tkt_engine #(
    parameter int TABLE_DEPTH = tkt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [tkt_pkg::KEY_W-1:0]  unused_key_code,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_kind,
    input  logic [tkt_pkg::KEY_W-1:0]  in_key,
    input  logic [tkt_pkg::GRP_W-1:0]  in_group,
    input  logic [4*tkt_pkg::VAL_W-1:0] in_values,
    output logic                       res_valid,
    input  logic                       res_ready,
    output tkt_pkg::res_t              res
);
    import tkt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_FWAIT = 3'd2;
    localparam logic [2:0] S_SRCH  = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // table storage
    logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
    logic [VAL_W-1:0] val_mem [TABLE_DEPTH];

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [IDX_W-1:0] send_reg, send_next;
    logic             sticky_reg, sticky_next;

    logic [KEY_W-1:0] key_reg;
    logic [GRP_W-1:0] grp_reg;
    logic [VAL_W-1:0] vals_reg [GRP_MAX];

    logic [CNT_W-1:0] srch_reg, srch_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0] first_reg, first_next;
    logic             alloc_reg, alloc_next;
    logic [1:0]       wcnt_reg, wcnt_next;
    res_t             res_reg, res_next;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [KEY_W-1:0] key_rd_reg;
    logic [VAL_W-1:0] val_rd_reg;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [SUM_W-1:0] wr_sum;
    logic [IDX_W-1:0] fsel;
    logic             hit;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // fetch slot: a stale pointer falls back to slot 0
    assign fsel = (CNT_W'(send_reg) < used_reg) ? send_reg : '0;
    assign hit  = cmp_vld_reg && (key_rd_reg == key_reg);
    assign wr_sum  = SUM_W'(first_reg) + SUM_W'(wcnt_reg);
    assign wr_addr = wr_sum[IDX_W-1:0];

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        used_next    = used_reg;
        send_next    = send_reg;
        sticky_next  = sticky_reg;
        srch_next    = srch_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        first_next   = first_reg;
        alloc_next   = alloc_reg;
        wcnt_next    = wcnt_reg;
        res_next     = res_reg;
        rd_en        = 1'b0;
        rd_addr      = fsel;
        wr_en        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    srch_next  = '0;
                    state_next = (in_kind == KIND_FETCH) ? S_FETCH : S_SRCH;
                end
            end
            S_FETCH:
            begin
                if (used_reg == '0)
                begin
                    res_next.status     = ST_FETCH;
                    res_next.slot_index = '0;
                    res_next.pair_key   = unused_key_code;
                    res_next.pair_value = '0;
                    res_next.full_error = sticky_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = fsel;
                    first_next = fsel;
                    if (CNT_W'(fsel) + CNT_W'(1) == used_reg)
                        send_next = '0;
                    else
                        send_next = fsel + IDX_W'(1);
                    state_next = S_FWAIT;
                end
            end
            S_FWAIT:
            begin
                res_next.status     = ST_FETCH;
                res_next.slot_index = SLOT_OUT_W'(first_reg);
                res_next.pair_key   = key_rd_reg;
                res_next.pair_value = val_rd_reg;
                res_next.full_error = sticky_reg;
                state_next = S_DONE;
            end
            S_SRCH:
            begin
                // one read issued per cycle, compared the cycle after
                if (hit)
                begin
                    first_next = cmp_idx_reg;
                    alloc_next = 1'b0;
                    wcnt_next  = '0;
                    state_next = S_WRITE;
                end
                else if (srch_reg < used_reg)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = srch_reg[IDX_W-1:0];
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = srch_reg[IDX_W-1:0];
                    srch_next    = srch_reg + CNT_W'(1);
                end
                else if (!cmp_vld_reg)
                begin
                    if (SUM_W'(used_reg) + SUM_W'(grp_reg) > SUM_W'(TABLE_DEPTH))
                    begin
                        sticky_next         = 1'b1;
                        res_next.status     = ST_FULL;
                        res_next.slot_index = SLOT_OUT_W'(TABLE_DEPTH);
                        res_next.pair_key   = '0;
                        res_next.pair_value = '0;
                        res_next.full_error = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        first_next = used_reg[IDX_W-1:0];
                        used_next  = used_reg + CNT_W'(grp_reg);
                        alloc_next = 1'b1;
                        wcnt_next  = '0;
                        state_next = S_WRITE;
                    end
                end
            end
            S_WRITE:
            begin
                // values past the table end are dropped
                wr_en     = (wr_sum < SUM_W'(TABLE_DEPTH));
                wcnt_next = wcnt_reg + 2'd1;
                if (GRP_W'(wcnt_reg) == grp_reg - GRP_W'(1))
                begin
                    res_next.status     = alloc_reg ? ST_ALLOC : ST_UPDATED;
                    res_next.slot_index = SLOT_OUT_W'(first_reg);
                    res_next.pair_key   = '0;
                    res_next.pair_value = '0;
                    res_next.full_error = sticky_reg;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            send_reg    <= '0;
            sticky_reg  <= 1'b0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            send_reg    <= send_next;
            sticky_reg  <= sticky_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    // item capture and working registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            key_reg  <= in_key;
            grp_reg  <= norm_group(in_group);
            for (int i = 0; i < GRP_MAX; i++)
                vals_reg[i] <= in_values[i*VAL_W +: VAL_W];
        end
        srch_reg    <= srch_next;
        cmp_idx_reg <= cmp_idx_next;
        first_reg   <= first_next;
        alloc_reg   <= alloc_next;
        wcnt_reg    <= wcnt_next;
        res_reg     <= res_next;
    end

    // synchronous read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            key_rd_reg <= key_mem[rd_addr];
            val_rd_reg <= val_mem[rd_addr];
        end
    end

    // write port, keys only on a new allocation
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            val_mem[wr_addr] <= vals_reg[wcnt_reg];
            if (alloc_reg)
                key_mem[wr_addr] <= key_reg;
        end
    end

endmodule

[bench/slot_table_checker.sv]
`timescale 1ns / 100ps

module slot_table_checker #(
    parameter int                             DEPTH         = tkt_pkg::TABLE_DEPTH_DEF,
    parameter logic [tkt_pkg::APB_ADDR_W-1:0] KEY_CODE_ADDR = '0
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // fields from bit 0: app_key, group_size, value_0, value_1, value_2, value_3, zero pad
    input  logic [tkt_pkg::IN_DATA_W-1:0]    s_tdata,
    // fields from bit 0: kind
    input  logic                             s_tuser,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // fields from bit 0: status, slot_index, pair_key, pair_value, full_error
    input  logic [tkt_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tkt_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tkt_pkg::APB_DATA_W-1:0]   pwdata,
    input  logic [tkt_pkg::APB_DATA_W-1:0]   prdata,
    input  logic                             pready,
    output int                               errors,
    output int                               pending,
    output int                               checked
);
    import tkt_pkg::*;

    localparam int PAD_W = IN_DATA_W - 4 * VAL_W - GRP_W - KEY_W;

    // one input beat as it lies in s_tdata
    typedef struct packed {
        logic [PAD_W-1:0] pad;
        logic [VAL_W-1:0] value_3;
        logic [VAL_W-1:0] value_2;
        logic [VAL_W-1:0] value_1;
        logic [VAL_W-1:0] value_0;
        logic [GRP_W-1:0] group_size;
        logic [KEY_W-1:0] app_key;
    } table_beat_t;

    // shadow of the slot table
    logic [KEY_W-1:0] slot_key [DEPTH];
    logic [VAL_W-1:0] slot_val [DEPTH];
    int               fill_count;
    int               rr_slot;
    bit               full_seen;
    logic [KEY_W-1:0] empty_code;

    res_t             pending_answers[$];
    res_t             want;
    res_t             got;
    int               k;

    task automatic compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // advance the shadow table by one beat and return the answer it owes
    function automatic res_t apply_table_item(logic kind, table_beat_t b);
        res_t             r;
        int               g;
        int               first;
        int               s;
        int               i;
        bit               hit;
        logic [VAL_W-1:0] data [4];
        r = '0;
        if (kind == KIND_FETCH)
        begin
            r.status = ST_FETCH;
            if (fill_count == 0)
                r.pair_key = empty_code;
            else
            begin
                // stale pointer falls back to the first slot
                s = (rr_slot < fill_count) ? rr_slot : 0;
                r.slot_index = SLOT_OUT_W'(s);
                r.pair_key   = slot_key[s];
                r.pair_value = slot_val[s];
                rr_slot      = (s + 1) % fill_count;
            end
            r.full_error = full_seen;
            return r;
        end

        // out-of-range group sizes clamp to 1..GRP_MAX
        g = b.group_size;
        if (g == 0)
            g = 1;
        else if (g > GRP_MAX)
            g = GRP_MAX;
        data[0] = b.value_0;
        data[1] = b.value_1;
        data[2] = b.value_2;
        data[3] = b.value_3;

        // first match among the used slots
        hit   = 0;
        first = 0;
        for (i = 0; i < fill_count && i < DEPTH; i++)
        begin
            if (!hit && slot_key[i] == b.app_key)
            begin
                hit   = 1;
                first = i;
            end
        end

        // new key: allocate a run after the used slots or reject
        if (!hit)
        begin
            if (fill_count + g > DEPTH)
            begin
                full_seen    = 1;
                r.status     = ST_FULL;
                r.slot_index = SLOT_OUT_W'(DEPTH);
                r.full_error = 1'b1;
                return r;
            end
            first = fill_count;
            for (i = 0; i < g; i++)
                slot_key[first + i] = b.app_key;
            fill_count += g;
        end

        // write the group, dropping anything past the table end
        for (i = 0; i < g; i++)
        begin
            if (first + i < DEPTH)
                slot_val[first + i] = data[i];
        end
        r.status     = hit ? ST_UPDATED : ST_ALLOC;
        r.slot_index = SLOT_OUT_W'(first);
        r.full_error = full_seen;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_code = '0;
            for (k = 0; k < DEPTH; k++)
            begin
                slot_key[k] = '0;
                slot_val[k] = '0;
            end
            fill_count = 0;
            rr_slot    = 0;
            full_seen  = 0;
            pending_answers.delete();
            errors     = 0;
            checked    = 0;
            pending    = 0;
        end
        else
        begin
            // result beat against the oldest open answer
            if (m_tvalid && m_tready)
            begin
                got = res_t'(m_tdata);
                if (pending_answers.size() == 0)
                begin
                    $error("result beat 0x%0h with no answer outstanding", m_tdata);
                    errors++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    compare_field("status", want.status, got.status);
                    compare_field("slot_index", want.slot_index, got.slot_index);
                    compare_field("pair_key", want.pair_key, got.pair_key);
                    compare_field("pair_value", want.pair_value, got.pair_value);
                    compare_field("full_error", want.full_error, got.full_error);
                    checked++;
                end
            end

            // register access
            if (psel && penable && pready && paddr == KEY_CODE_ADDR)
            begin
                if (pwrite)
                    empty_code = pwdata[KEY_W-1:0];
                else
                    compare_field("unused_key_code", {16'b0, empty_code}, prdata);
            end

            // input beat
            if (s_tvalid && s_tready)
                pending_answers.push_back(apply_table_item(s_tuser, table_beat_t'(s_tdata)));

            pending = pending_answers.size();
        end
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;
    import tkt_pkg::*;

    localparam int                    DEPTH         = TABLE_DEPTH_DEF;
    localparam logic [APB_ADDR_W-1:0] KEY_CODE_ADDR = '0;
    localparam int                    PHASE_BEATS   = 445;
    localparam int                    DRAIN_CYCLES  = DEPTH + GRP_MAX + 8;
    localparam int                    STALL_LIMIT   = 4000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int errors;
    int pending;
    int checked;
    int send_idle = 0;
    int recv_idle = 0;
    int beats_sent = 0;
    int directed_beats = 0;
    int code_writes = 0;
    int idle_cycles = 0;
    int ph;
    int n;

    // keys that the directed part allocates
    logic [KEY_W-1:0] known_keys [7] = '{16'h0000, 16'hFFFF, 16'h8001, 16'h7FFE,
                                         16'h5A5A, 16'hA5A5, 16'h0F0F};

    always #1 clk = ~clk;

    telemetry_key_table_round_robin_top #(.TABLE_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    slot_table_checker #(.DEPTH(DEPTH), .KEY_CODE_ADDR(KEY_CODE_ADDR)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .errors(errors), .pending(pending), .checked(checked)
    );

    // receiver back-pressure
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    // watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // one input beat, with random sender gaps in front
    task automatic push_beat(logic kind, logic [KEY_W-1:0] key, logic [GRP_W-1:0] grp,
                             logic [VAL_W-1:0] v0, logic [VAL_W-1:0] v1,
                             logic [VAL_W-1:0] v2, logic [VAL_W-1:0] v3);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tdata  = {v3, v2, v1, v0, grp, key};
        s_tuser  = kind;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        s_tvalid = 1'b0;
        beats_sent++;
    endtask

    task automatic fetch_beat();
        push_beat(KIND_FETCH, KEY_W'($urandom), GRP_W'($urandom), $urandom, $urandom,
                  $urandom, $urandom);
    endtask

    task automatic update_beat(logic [KEY_W-1:0] key, logic [GRP_W-1:0] grp,
                               logic [VAL_W-1:0] v0);
        push_beat(KIND_UPDATE, key, grp, v0, $urandom, $urandom, $urandom);
    endtask

    // hold off until every answer is back and the engine has settled
    task automatic wait_drained();
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apb_access(logic wr, logic [APB_DATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = KEY_CODE_ADDR;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // key-code change while idle, then read it back
    task automatic set_key_code(logic [KEY_W-1:0] code);
        wait_drained();
        apb_access(1'b1, {16'b0, code});
        apb_access(1'b0, '0);
        code_writes++;
    endtask

    // mixed random beat: fetches, updates of known keys, strays that get rejected
    task automatic random_beat();
        int               r;
        logic [GRP_W-1:0] g;
        logic [KEY_W-1:0] key;
        r = $urandom_range(99);
        g = ($urandom_range(7) == 0) ? GRP_W'($urandom_range(7))
                                     : GRP_W'($urandom_range(1, GRP_MAX));
        key = (r < 85) ? known_keys[$urandom_range(6)] : KEY_W'($urandom);
        if (r < 45)
            fetch_beat();
        else
            update_beat(key, g, $urandom);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty table under several key codes
        fetch_beat();
        set_key_code(16'hFFFF);
        fetch_beat();
        set_key_code(16'h1234);
        fetch_beat();

        // fill the table step by step
        update_beat(known_keys[0], 3'd1, 32'h0000_0000);
        update_beat(known_keys[1], 3'd0, 32'hFFFF_FFFF);
        fetch_beat();
        fetch_beat();
        fetch_beat();
        // existing key with a wider group spills onto later slots
        push_beat(KIND_UPDATE, known_keys[1], 3'd7, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
        update_beat(known_keys[2], 3'd4, $urandom);
        update_beat(known_keys[3], 3'd5, $urandom);
        update_beat(known_keys[4], 3'd3, $urandom);
        update_beat(known_keys[5], 3'd2, $urandom);
        // group too large for the room left
        update_beat(known_keys[6], 3'd2, $urandom);
        update_beat(known_keys[6], 3'd1, $urandom);
        // last slot with a group running past the end
        update_beat(known_keys[6], 3'd4, $urandom);
        update_beat(known_keys[2], 3'd6, $urandom);
        update_beat(16'h4242, 3'd1, $urandom);
        repeat (4) fetch_beat();
        directed_beats = beats_sent;
        wait_drained();

        // random part under three idle mixes
        for (ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 20 : (ph == 1) ? 76 : 0;
            recv_idle = (ph == 0) ? 76 : (ph == 1) ? 20 : 0;
            for (n = 0; n < PHASE_BEATS; n++)
            begin
                random_beat();
                if ($urandom_range(149) == 0)
                    wait_drained();
            end
            if (ph == 0)
                set_key_code(KEY_W'($urandom_range(1, 16'hFFFE)));
            else
                set_key_code((ph == 1) ? 16'hFFFF : 16'h0000);
        end

        wait_drained();
        repeat (30) @(negedge clk);
        $display("%0d input beats sent (%0d directed), %0d result beats checked",
                 beats_sent, directed_beats, checked);
        $display("%0d key-code writes, three sender/receiver idle mixes", code_writes);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
sv/tkt_pkg.sv
sv/tkt_engine.sv
sv/telemetry_key_table_round_robin_top.sv
bench/slot_table_checker.sv
bench/tb.sv
